>>> hdl/ptrm_pkg.sv
package ptrm_pkg;

  localparam int GridBits = 6;
  localparam int CoordW   = 17;
  localparam int GridW    = 6;

  localparam logic [GridW-1:0] GridMask = GridW'((1 << GridBits) - 1);

  localparam logic [2:0] CfgTargetXGrid = 3'd0;
  localparam logic [2:0] CfgTargetYGrid = 3'd1;
  localparam logic [2:0] CfgSourceXGrid = 3'd2;
  localparam logic [2:0] CfgSourceYGrid = 3'd3;
  localparam logic [2:0] CfgAreaX       = 3'd4;
  localparam logic [2:0] CfgAreaY       = 3'd5;

  typedef struct packed {
    logic [GridW-1:0] tgx;
    logic [GridW-1:0] tgy;
    logic [GridW-1:0] sgx;
    logic [GridW-1:0] sgy;
    logic [1:0]       ax;
    logic [1:0]       ay;
  } cfg_t;

  // One classified pad: the fine-grid search window and walk steps.
  typedef struct packed {
    logic [1:0]        quarter;
    logic [CoordW-1:0] min_x;
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] min_y;
    logic [CoordW-1:0] max_y;
    logic [GridW-1:0]  fgx;
    logic [GridW-1:0]  fgy;
    logic [GridW-1:0]  step_x;
    logic [GridW-1:0]  step_y;
  } setup_t;

  function automatic logic [GridW-1:0] grid_val(logic [GridW-1:0] g);
    logic [GridW-1:0] m;
    m = g & GridMask;
    return (m == '0) ? GridW'(1) : m;
  endfunction

  // Region of one fine coordinate: (c-1)/g compared against 1, 3 and 7.
  function automatic logic [2:0] axis_region(logic [CoordW-1:0] c, logic [GridW-1:0] g);
    logic [CoordW-1:0] cm1;
    logic [CoordW-1:0] g1;
    cm1 = c - CoordW'(1);
    g1  = CoordW'(g);
    if (cm1 < g1) return 3'd0;
    else if (cm1 < (g1 << 1)) return 3'd1;
    else if (cm1 < (g1 << 2)) return 3'd2;
    else if (cm1 < (g1 << 3)) return 3'd3;
    else return 3'd4;
  endfunction

  function automatic logic [2:0] fine_region(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                             logic [GridW-1:0] gx, logic [GridW-1:0] gy);
    logic [2:0] rx;
    logic [2:0] ry;
    logic [2:0] r;
    rx = axis_region(x, gx);
    ry = axis_region(y, gy);
    r  = (rx > ry) ? rx : ry;
    return (r == 3'd0) ? 3'd1 : r;
  endfunction

endpackage

>>> hdl/pad_to_tile_region_mapper_core.sv
// Maps one detector pad onto every target-layout tile it touches, widened by the
// configured search area. The front end takes a pad, derives the grid ratios with a
// pair of small bit-serial dividers and the fine-grid window, and queues it (two
// entries). The back end walks each window twice: a counting pass at one touched
// tile per cycle (at most MAX_TILES+1), then an emitting pass that divides both fine
// coordinates down to tile indices with a pair of 17-bit one-bit-per-cycle dividers,
// which are skipped when the fine grid equals the target grid.
// Output pace also depends on out_stall_i.
module pad_to_tile_region_mapper_core #(
  parameter int MAX_TILES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  pad_quarter_i,
  input  logic [2:0]  pad_region_i,
  input  logic [6:0]  pad_x_i,
  input  logic [6:0]  pad_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  tile_quarter_o,
  output logic [2:0]  tile_region_o,
  output logic [12:0] tile_x_o,
  output logic [12:0] tile_y_o,
  output logic        last_tile_o,
  output logic        overflow_o
);
  import ptrm_pkg::*;

  logic [GridW-1:0] tgx_q, tgy_q, sgx_q, sgy_q;
  logic [1:0]       ax_q, ay_q;
  cfg_t             cfg;
  logic             push, pop, full, empty;
  setup_t           push_data, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgx_q <= GridW'(1);
      tgy_q <= GridW'(1);
      sgx_q <= GridW'(1);
      sgy_q <= GridW'(1);
      ax_q  <= '0;
      ay_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTargetXGrid: tgx_q <= cfg_data_i;
        CfgTargetYGrid: tgy_q <= cfg_data_i;
        CfgSourceXGrid: sgx_q <= cfg_data_i;
        CfgSourceYGrid: sgy_q <= cfg_data_i;
        CfgAreaX:       ax_q  <= cfg_data_i[1:0];
        CfgAreaY:       ay_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg.tgx = grid_val(tgx_q);
  assign cfg.tgy = grid_val(tgy_q);
  assign cfg.sgx = grid_val(sgx_q);
  assign cfg.sgy = grid_val(sgy_q);
  assign cfg.ax  = ax_q;
  assign cfg.ay  = ay_q;

  ptrm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pad_quarter_i, .pad_region_i, .pad_x_i, .pad_y_i,
    .cfg_i(cfg), .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  ptrm_fifo #(.Width($bits(setup_t)), .Depth(2)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .pop_i(pop),
    .head_o(head), .full_o(full), .empty_o(empty)
  );

  ptrm_back #(.MaxTiles(MAX_TILES)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .setup_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .tile_quarter_o, .tile_region_o,
    .tile_x_o, .tile_y_o, .last_tile_o, .overflow_o
  );

endmodule

>>> hdl/ptrm_div.sv
module ptrm_div #(
  parameter int DivdW = 17,
  parameter int DivsW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivdW-1:0] dividend_i,
  input  logic [DivsW-1:0] divisor_i,
  output logic             busy_o,
  output logic [DivdW-1:0] quotient_o
);

  localparam int CntW = $clog2(DivdW + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivdW-1:0] quo_q;
  logic [DivsW-1:0] rem_q;
  logic [DivsW-1:0] dvs_q;
  logic [DivsW:0]   shifted;
  logic [DivsW:0]   diff;
  logic             ge;
  logic             unit_div;

  assign shifted  = {rem_q, quo_q[DivdW-1]};
  assign diff     = shifted - {1'b0, dvs_q};
  assign ge       = shifted >= {1'b0, dvs_q};
  assign unit_div = divisor_i == DivsW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !unit_div;
      cnt_q  <= CntW'(DivdW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle; a divisor of one skips it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivdW-2:0], ge};
      rem_q <= ge ? diff[DivsW-1:0] : shifted[DivsW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/ptrm_fifo.sv
module ptrm_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q;
  logic [PtrW-1:0]  rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/ptrm_front.sv
module ptrm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       pad_quarter_i,
  input  logic [2:0]       pad_region_i,
  input  logic [6:0]       pad_x_i,
  input  logic [6:0]       pad_y_i,
  input  ptrm_pkg::cfg_t   cfg_i,
  output logic             push_o,
  output ptrm_pkg::setup_t push_data_o,
  input  logic             full_i
);
  import ptrm_pkg::*;

  typedef enum logic [5:0] {
    FIdle = 6'b000001,
    FDiv1 = 6'b000010,
    FDiv2 = 6'b000100,
    FMul  = 6'b001000,
    FSum  = 6'b010000,
    FPush = 6'b100000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [1:0]        quarter_q;
  logic [1:0]        shift_q;
  logic [6:0]        px_q, py_q;
  logic [GridW-1:0]  rxs_q, rys_q, rxw_q, ryw_q;
  logic [13:0]       mx_q, my_q;
  logic [8:0]        ux_q, uy_q;
  setup_t            setup_q;

  logic [GridW-1:0]  fgx, fgy;
  logic              accept, div_start, div_idle;
  logic [GridW-1:0]  dvd_x, dvd_y, dvs_x, dvs_y;
  logic              busy_x, busy_y;
  logic [GridW-1:0]  q_x, q_y;
  logic [1:0]        shift_in;
  logic [7:0]        sum_x, sum_y;
  logic [CoordW-1:0] max_x, max_y, span_x, span_y;
  logic [CoordW:0]   lo_x, lo_y;

  assign fgx = (cfg_i.tgx > cfg_i.sgx) ? cfg_i.tgx : cfg_i.sgx;
  assign fgy = (cfg_i.tgy > cfg_i.sgy) ? cfg_i.tgy : cfg_i.sgy;

  assign accept     = in_valid_i && (state_q == FIdle);
  assign in_stall_o = state_q != FIdle;
  assign div_idle   = !busy_x && !busy_y;
  assign div_start  = accept || ((state_q == FDiv1) && div_idle);

  // First pass: target over source grid; second pass: fine over target grid.
  assign dvd_x = (state_q == FIdle) ? cfg_i.tgx : fgx;
  assign dvd_y = (state_q == FIdle) ? cfg_i.tgy : fgy;
  assign dvs_x = (state_q == FIdle) ? cfg_i.sgx : cfg_i.tgx;
  assign dvs_y = (state_q == FIdle) ? cfg_i.sgy : cfg_i.tgy;

  ptrm_div #(.DivdW(GridW), .DivsW(GridW)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_x), .divisor_i(dvs_x),
    .busy_o(busy_x), .quotient_o(q_x)
  );

  ptrm_div #(.DivdW(GridW), .DivsW(GridW)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_y), .divisor_i(dvs_y),
    .busy_o(busy_y), .quotient_o(q_y)
  );

  always_comb begin
    if (pad_region_i <= 3'd1) begin
      shift_in = 2'd0;
    end else if (pad_region_i >= 3'd4) begin
      shift_in = 2'd3;
    end else begin
      shift_in = 2'(pad_region_i - 3'd1);
    end
  end

  assign sum_x  = 8'(px_q) + 8'(cfg_i.ax);
  assign sum_y  = 8'(py_q) + 8'(cfg_i.ay);
  assign max_x  = CoordW'(mx_q) << shift_q;
  assign max_y  = CoordW'(my_q) << shift_q;
  assign span_x = CoordW'(ux_q) << shift_q;
  assign span_y = CoordW'(uy_q) << shift_q;
  assign lo_x   = {1'b0, max_x} - {1'b0, span_x} + (CoordW+1)'(1);
  assign lo_y   = {1'b0, max_y} - {1'b0, span_y} + (CoordW+1)'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FIdle: if (accept) state_d = FDiv1;
      FDiv1: if (div_idle) state_d = FDiv2;
      FDiv2: if (div_idle) state_d = FMul;
      FMul:  state_d = FSum;
      FSum:  state_d = FPush;
      FPush: if (!full_i) state_d = FIdle;
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      quarter_q <= pad_quarter_i;
      shift_q   <= shift_in;
      px_q      <= pad_x_i;
      py_q      <= pad_y_i;
    end
    if ((state_q == FDiv1) && div_idle) begin
      rxs_q <= (q_x == '0) ? GridW'(1) : q_x;
      rys_q <= (q_y == '0) ? GridW'(1) : q_y;
    end
    if ((state_q == FDiv2) && div_idle) begin
      rxw_q <= q_x;
      ryw_q <= q_y;
    end
    if (state_q == FMul) begin
      mx_q <= 14'(sum_x) * 14'(rxs_q);
      my_q <= 14'(sum_y) * 14'(rys_q);
      ux_q <= 9'({cfg_i.ax, 1'b1}) * 9'(rxs_q);
      uy_q <= 9'({cfg_i.ay, 1'b1}) * 9'(rys_q);
    end
    if (state_q == FSum) begin
      setup_q.quarter <= quarter_q;
      setup_q.max_x   <= max_x;
      setup_q.max_y   <= max_y;
      // The lower corner never goes below one.
      setup_q.min_x   <= (lo_x[CoordW] || lo_x == '0) ? CoordW'(1) : lo_x[CoordW-1:0];
      setup_q.min_y   <= (lo_y[CoordW] || lo_y == '0) ? CoordW'(1) : lo_y[CoordW-1:0];
      setup_q.fgx     <= fgx;
      setup_q.fgy     <= fgy;
      setup_q.step_x  <= rxw_q;
      setup_q.step_y  <= ryw_q;
    end
  end

  assign push_o      = (state_q == FPush) && !full_i;
  assign push_data_o = setup_q;

endmodule

>>> hdl/ptrm_back.sv
module ptrm_back #(
  parameter int MaxTiles = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  ptrm_pkg::setup_t setup_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       tile_quarter_o,
  output logic [2:0]       tile_region_o,
  output logic [12:0]      tile_x_o,
  output logic [12:0]      tile_y_o,
  output logic             last_tile_o,
  output logic             overflow_o
);
  import ptrm_pkg::*;

  localparam int CntW = $clog2(MaxTiles + 2);

  typedef enum logic [4:0] {
    BIdle  = 5'b00001,
    BCount = 5'b00010,
    BStart = 5'b00100,
    BWait  = 5'b01000,
    BOut   = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [CoordW-1:0] ix_q, iy_q;
  logic              wdone_q;
  logic [CntW-1:0]   cnt_q, n_q, ecnt_q;
  logic              over_q;
  logic [2:0]        nr_q;
  logic              out_valid_q;
  logic [1:0]        quarter_q;
  logic [2:0]        region_q;
  logic [12:0]       tx_q, ty_q;
  logic              last_q, ovf_q;

  logic [2:0]        nr_pt, nr_col;
  logic [1:0]        sh_pt, sh_col;
  logic [CoordW-1:0] iy_nxt, ix_nxt;
  logic [CoordW-1:0] adv_ix, adv_iy;
  logic              adv_done, init_done;
  logic              walk_init, walk_adv;
  logic              cnt_full, div_start, busy_x, busy_y;
  logic [CoordW-1:0] dvd_x, dvd_y, q_x, q_y;
  logic [CntW-1:0]   n_tot;
  logic              is_last;

  assign nr_pt  = fine_region(ix_q, iy_q, setup_i.fgx, setup_i.fgy);
  assign nr_col = fine_region(ix_q, setup_i.min_y, setup_i.fgx, setup_i.fgy);
  assign sh_pt  = 2'(nr_pt - 3'd1);
  assign sh_col = 2'(nr_col - 3'd1);
  assign iy_nxt = iy_q + (CoordW'(setup_i.step_y) << sh_pt);
  assign ix_nxt = ix_q + (CoordW'(setup_i.step_x) << sh_col);

  // Rows advance inside a column; the column step uses the region at its bottom row.
  always_comb begin
    if (iy_nxt <= setup_i.max_y) begin
      adv_ix   = ix_q;
      adv_iy   = iy_nxt;
      adv_done = 1'b0;
    end else begin
      adv_ix   = ix_nxt;
      adv_iy   = setup_i.min_y;
      adv_done = ix_nxt > setup_i.max_x;
    end
  end

  assign init_done = (setup_i.min_x > setup_i.max_x) || (setup_i.min_y > setup_i.max_y);
  assign cnt_full  = cnt_q == CntW'(MaxTiles + 1);
  assign n_tot     = cnt_full ? CntW'(MaxTiles) : cnt_q;
  assign is_last   = (ecnt_q + CntW'(1)) == n_q;

  always_comb begin
    state_d   = state_q;
    walk_init = 1'b0;
    walk_adv  = 1'b0;
    pop_o     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      BIdle: begin
        if (!empty_i) begin
          walk_init = 1'b1;
          state_d   = BCount;
        end
      end
      BCount: begin
        if (!wdone_q && !cnt_full) begin
          walk_adv = 1'b1;
        end else if (n_tot == '0) begin
          pop_o   = 1'b1;
          state_d = BIdle;
        end else begin
          walk_init = 1'b1;
          state_d   = BStart;
        end
      end
      BStart: begin
        div_start = 1'b1;
        state_d   = BWait;
      end
      BWait: if (!busy_x && !busy_y) state_d = BOut;
      BOut: begin
        if (!out_stall_i) begin
          if (last_q) begin
            pop_o   = 1'b1;
            state_d = BIdle;
          end else begin
            walk_adv = 1'b1;
            state_d  = BStart;
          end
        end
      end
      default: state_d = BIdle;
    endcase
  end

  assign dvd_x = (ix_q - CoordW'(1)) >> sh_pt;
  assign dvd_y = (iy_q - CoordW'(1)) >> sh_pt;

  ptrm_div #(.DivdW(CoordW), .DivsW(GridW)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_x), .divisor_i(setup_i.step_x),
    .busy_o(busy_x), .quotient_o(q_x)
  );

  ptrm_div #(.DivdW(CoordW), .DivsW(GridW)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_y), .divisor_i(setup_i.step_y),
    .busy_o(busy_y), .quotient_o(q_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == BWait) && !busy_x && !busy_y) begin
        out_valid_q <= 1'b1;
      end else if ((state_q == BOut) && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_init) begin
      ix_q    <= setup_i.min_x;
      iy_q    <= setup_i.min_y;
      wdone_q <= init_done;
    end else if (walk_adv) begin
      ix_q    <= adv_ix;
      iy_q    <= adv_iy;
      wdone_q <= adv_done;
    end
    if (state_q == BIdle) begin
      cnt_q <= '0;
    end else if ((state_q == BCount) && walk_adv) begin
      cnt_q <= cnt_q + CntW'(1);
    end
    if ((state_q == BCount) && walk_init) begin
      n_q    <= n_tot;
      over_q <= cnt_full;
      ecnt_q <= '0;
    end else if ((state_q == BOut) && walk_adv) begin
      ecnt_q <= ecnt_q + CntW'(1);
    end
    if (state_q == BStart) begin
      nr_q <= nr_pt;
    end
    if ((state_q == BWait) && !busy_x && !busy_y) begin
      quarter_q <= setup_i.quarter;
      region_q  <= nr_q;
      tx_q      <= q_x[12:0] + 13'd1;
      ty_q      <= q_y[12:0] + 13'd1;
      last_q    <= is_last;
      ovf_q     <= over_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tile_quarter_o = quarter_q;
  assign tile_region_o  = region_q;
  assign tile_x_o       = tx_q;
  assign tile_y_o       = ty_q;
  assign last_tile_o    = last_q;
  assign overflow_o     = ovf_q;

endmodule

>>> hdl/ptrm_checker.sv
module ptrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  tile_region_o,
  input logic [12:0] tile_x_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tile_x_o))
    else $error("stalled result changed");

  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tile_region_o >= 3'd1 && tile_region_o <= 3'd4)
    else $error("tile region out of range");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front took a second pad without setup time");

  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result shown again right after its transaction");

endmodule

bind pad_to_tile_region_mapper_core ptrm_checker u_ptrm_checker (.*);

>>> tb/tb_pad_to_tile_region_mapper_core.sv
`timescale 1ns / 1ps

module tb_pad_to_tile_region_mapper_core;
  import ptrm_pkg::*;

  localparam int MaxTiles   = 64;
  localparam int DrainWait  = 3000;

  typedef struct {
    logic [1:0]  quarter;
    logic [2:0]  region;
    logic [12:0] x;
    logic [12:0] y;
    logic        last;
    logic        ovf;
  } tile_t;

  typedef enum int {ByPredictor, OneTile, NoTile} row_kind_e;

  typedef struct {
    logic [1:0]  quarter;
    logic [2:0]  region;
    logic [6:0]  px;
    logic [6:0]  py;
    row_kind_e   kind;
    logic [2:0]  exp_region;
    logic [12:0] exp_x;
    logic [12:0] exp_y;
  } pad_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [5:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  pad_quarter_i = '0;
  logic [2:0]  pad_region_i = '0;
  logic [6:0]  pad_x_i = '0;
  logic [6:0]  pad_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  tile_quarter_o;
  logic [2:0]  tile_region_o;
  logic [12:0] tile_x_o;
  logic [12:0] tile_y_o;
  logic        last_tile_o;
  logic        overflow_o;

  pad_to_tile_region_mapper_core #(.MAX_TILES(MaxTiles)) DUT (.*);

  always #5 clk_i = ~clk_i;

  // Local copy of the register file.
  logic [5:0] tgx_q = 6'd1, tgy_q = 6'd1, sgx_q = 6'd1, sgy_q = 6'd1;
  logic [1:0] ax_q = '0, ay_q = '0;

  tile_t tiles_pending[$];
  int    n_errors = 0;
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    hold_cycles = 0;

  task automatic report(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic int grid_of(logic [5:0] g);
    return (g == 6'd0) ? 1 : int'(g);
  endfunction

  function automatic int band_of(int c, int g);
    int q;
    q = (c - 1) / g;
    if (q < 1) return 0;
    if (q == 1) return 1;
    if (q <= 3) return 2;
    if (q <= 7) return 3;
    return 4;
  endfunction

  function automatic int region_at(int x, int y, int gx, int gy);
    int rx, ry, r;
    rx = band_of(x, gx);
    ry = band_of(y, gy);
    r = (rx > ry) ? rx : ry;
    return (r == 0) ? 1 : r;
  endfunction

  // Appends the tiles touched by one pad to tiles_pending.
  function automatic void map_pad(logic [1:0] quarter, logic [2:0] region,
                                  logic [6:0] px, logic [6:0] py);
    int tgx, tgy, sgx, sgy, ax, ay, nreg, rf, fgx, fgy, rx, ry;
    int max_x, max_y, min_x, min_y, ix, iy, nrx, nr, f;
    bit over;
    tile_t found[$];
    tile_t t;
    tgx = grid_of(tgx_q);
    tgy = grid_of(tgy_q);
    sgx = grid_of(sgx_q);
    sgy = grid_of(sgy_q);
    ax = ax_q;
    ay = ay_q;
    nreg = region;
    if (nreg < 1) nreg = 1;
    if (nreg > 4) nreg = 4;
    rf = 1 << (nreg - 1);
    fgx = (tgx > sgx) ? tgx : sgx;
    fgy = (tgy > sgy) ? tgy : sgy;
    rx = tgx / sgx;
    if (rx == 0) rx = 1;
    ry = tgy / sgy;
    if (ry == 0) ry = 1;
    max_x = (int'(px) + ax) * rf * rx;
    max_y = (int'(py) + ay) * rf * ry;
    min_x = max_x - rf * rx * (2 * ax + 1) + 1;
    min_y = max_y - rf * ry * (2 * ay + 1) + 1;
    if (min_x < 1) min_x = 1;
    if (min_y < 1) min_y = 1;
    rx = fgx / tgx;
    ry = fgy / tgy;
    over = 1'b0;
    ix = min_x;
    while (ix <= max_x && !over) begin
      nrx = region_at(ix, min_y, fgx, fgy);
      iy = min_y;
      while (iy <= max_y) begin
        nr = region_at(ix, iy, fgx, fgy);
        f = 1 << (nr - 1);
        if (found.size() >= MaxTiles) begin
          over = 1'b1;
          break;
        end
        t.quarter = quarter;
        t.region = 3'(nr);
        t.x = 13'((ix - 1) / f / rx + 1);
        t.y = 13'((iy - 1) / f / ry + 1);
        t.last = 1'b0;
        t.ovf = 1'b0;
        found.insert(found.size(), t);
        iy += f * ry;
      end
      ix += (1 << (nrx - 1)) * rx;
    end
    foreach (found[k]) begin
      found[k].last = (k == found.size() - 1);
      found[k].ovf = over;
      tiles_pending.insert(tiles_pending.size(), found[k]);
    end
  endfunction

  // Output checker.
  always @(posedge clk_i) begin
    tile_t e;
    if (out_valid_o && !out_stall_i) begin
      if (tiles_pending.size() == 0) begin
        report("unexpected tile, x", tile_x_o, -1);
      end else begin
        e = tiles_pending.pop_front();
        if (tile_quarter_o !== e.quarter) report("tile_quarter", tile_quarter_o, e.quarter);
        if (tile_region_o !== e.region) report("tile_region", tile_region_o, e.region);
        if (tile_x_o !== e.x) report("tile_x", tile_x_o, e.x);
        if (tile_y_o !== e.y) report("tile_y", tile_y_o, e.y);
        if (last_tile_o !== e.last) report("last_tile", last_tile_o, e.last);
        if (overflow_o !== e.ovf) report("overflow", overflow_o, e.ovf);
      end
    end
  end

  // Receiver: a long hold-off takes priority over random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [5:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgTargetXGrid: tgx_q = data;
      CfgTargetYGrid: tgy_q = data;
      CfgSourceXGrid: sgx_q = data;
      CfgSourceYGrid: sgy_q = data;
      CfgAreaX:       ax_q = data[1:0];
      default:        ay_q = data[1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(int tgx, int tgy, int sgx, int sgy, int ax, int ay);
    write_reg(CfgTargetXGrid, 6'(tgx));
    write_reg(CfgTargetYGrid, 6'(tgy));
    write_reg(CfgSourceXGrid, 6'(sgx));
    write_reg(CfgSourceYGrid, 6'(sgy));
    write_reg(CfgAreaX, 6'(ax));
    write_reg(CfgAreaY, 6'(ay));
  endtask

  // Called at a falling edge; leaves at the falling edge after the transaction.
  task automatic send_pad(logic [1:0] q, logic [2:0] r, logic [6:0] x, logic [6:0] y,
                          bit typed, tile_t want[$]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pad_quarter_i = q;
    pad_region_i = r;
    pad_x_i = x;
    pad_y_i = y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (typed) begin
      foreach (want[k]) tiles_pending.insert(tiles_pending.size(), want[k]);
    end else begin
      map_pad(q, r, x, y);
    end
    @(negedge clk_i);
  endtask

  task automatic send_random;
    tile_t none[$];
    send_pad(2'($urandom), 3'($urandom),
             ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(12)),
             ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(12)), 0, none);
  endtask

  task automatic drain;
    in_valid_i = 1'b0;
    while (tiles_pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    pad_row_t rows[$];
    tile_t want[$];
    tile_t t;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under reset configuration: all grids 1, no search area.
    rows = '{
      '{2'd0, 3'd1, 7'd1, 7'd1, OneTile, 3'd1, 13'd1, 13'd1},
      '{2'd1, 3'd1, 7'd2, 7'd1, OneTile, 3'd1, 13'd2, 13'd1},
      '{2'd2, 3'd1, 7'd0, 7'd5, NoTile, 3'd0, 13'd0, 13'd0},
      '{2'd3, 3'd2, 7'd5, 7'd0, NoTile, 3'd0, 13'd0, 13'd0},
      '{2'd3, 3'd0, 7'd3, 7'd3, ByPredictor, 3'd0, 13'd0, 13'd0},
      '{2'd2, 3'd2, 7'd3, 7'd6, ByPredictor, 3'd0, 13'd0, 13'd0},
      '{2'd1, 3'd3, 7'd9, 7'd2, ByPredictor, 3'd0, 13'd0, 13'd0},
      '{2'd0, 3'd4, 7'd127, 7'd127, ByPredictor, 3'd0, 13'd0, 13'd0},
      '{2'd3, 3'd5, 7'd64, 7'd1, ByPredictor, 3'd0, 13'd0, 13'd0},
      '{2'd1, 3'd7, 7'd127, 7'd0, NoTile, 3'd0, 13'd0, 13'd0},
      '{2'd2, 3'd6, 7'd1, 7'd127, ByPredictor, 3'd0, 13'd0, 13'd0}
    };
    foreach (rows[i]) begin
      want.delete();
      if (rows[i].kind == OneTile) begin
        t = '{rows[i].quarter, rows[i].exp_region, rows[i].exp_x, rows[i].exp_y, 1'b1, 1'b0};
        want.insert(want.size(), t);
      end
      send_pad(rows[i].quarter, rows[i].region, rows[i].px, rows[i].py,
               rows[i].kind != ByPredictor, want);
    end
    drain();

    // Extreme settings: zero grids, widest area, target coarser and finer than source.
    want.delete();
    write_all(0, 0, 0, 0, 3, 3);
    send_pad(2'd1, 3'd4, 7'd127, 7'd127, 0, want);
    send_pad(2'd0, 3'd1, 7'd0, 7'd0, 0, want);
    drain();
    write_all(63, 63, 1, 1, 3, 0);
    send_pad(2'd2, 3'd4, 7'd127, 7'd127, 0, want);
    send_pad(2'd3, 3'd1, 7'd1, 7'd1, 0, want);
    drain();
    write_all(1, 2, 63, 63, 0, 3);
    send_pad(2'd0, 3'd3, 7'd100, 7'd4, 0, want);
    send_pad(2'd1, 3'd2, 7'd127, 7'd127, 0, want);
    drain();

    // Back-pressure: receiver holds off while the sender keeps offering pads.
    write_all(2, 2, 1, 1, 1, 1);
    @(posedge clk_i);
    hold_cycles = 800;
    @(negedge clk_i);
    repeat (12) send_random();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 65 : (ph == 3) ? 33 : 0;
      stall_pct = (ph == 2) ? 65 : (ph == 3) ? 33 : 0;
      for (int sub = 0; sub < 3; sub++) begin
        write_all($urandom_range(63), $urandom_range(63), $urandom_range(63),
                  $urandom_range(63), $urandom_range(3), $urandom_range(3));
        repeat (30) send_random();
        drain();
      end
    end

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
